### hw/rtl/itp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the infix to postfix reorder unit: token and
// result formats, stack entry layout, token and result codes.
// ---------------------------------------------------------------------------
package itp_pkg;

	// operator stack geometry
	localparam int STACK_DEPTH = 16;
	localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

	// input token kinds
	localparam logic [2:0] KIND_VALUE = 3'd0;
	localparam logic [2:0] KIND_OPER  = 3'd1;
	localparam logic [2:0] KIND_OPEN  = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;

	// result kinds
	localparam logic [1:0] OK_VALUE = 2'd0;
	localparam logic [1:0] OK_OPER  = 2'd1;
	localparam logic [1:0] OK_NONE  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_PAREN    = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	// input token
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] payload;
		logic [3:0]  rank;
		logic        right_assoc;
	} tok_t;

	// output result
	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_payload;
		logic        last;
		logic [1:0]  error;
	} res_t;

	// one operator stack entry, 38 bits
	typedef struct packed {
		logic        paren;
		logic        right_assoc;
		logic [3:0]  rank;
		logic [31:0] payload;
	} stk_entry_t;

	// stack memory write and read request
	typedef struct packed {
		logic              we;
		logic [STK_AW-1:0] waddr;
		stk_entry_t        wdata;
		logic [STK_AW-1:0] raddr;
	} ram_req_t;

	// result handed to the output register
	typedef struct packed {
		logic valid;
		res_t res;
	} emit_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} st_t;

endpackage
`default_nettype wire

### hw/rtl/itp_stack_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_stack_ram
// Operator stack storage: one write port, one registered read port, with
// write data forwarded when both ports hit the same entry.
// ---------------------------------------------------------------------------
module itp_stack_ram (
	input  wire logic               clk,
	input  wire itp_pkg::ram_req_t  req,
	output itp_pkg::stk_entry_t     rdata
);
	import itp_pkg::*;

	stk_entry_t mem [STACK_DEPTH];
	stk_entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read port, forward a same-cycle write
	always_ff @(posedge clk) begin
		if (req.we && (req.waddr == req.raddr)) begin
			rdata_q <= req.wdata;
		end else begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/itp_out_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_out_reg
// Result output register: holds one result until the receiver takes it and
// tells the sequencer when a new result can be loaded.
// ---------------------------------------------------------------------------
module itp_out_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire itp_pkg::emit_t emit,
	output logic                free,
	output logic                res_valid,
	input  wire logic           res_ready,
	output itp_pkg::res_t       res
);
	import itp_pkg::*;

	logic valid_q;
	res_t data_q;

	// slot is usable when empty or drained this cycle
	assign free = !valid_q || res_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.valid) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result data
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			data_q <= emit.res;
		end
	end

	assign res_valid = valid_q;
	assign res       = data_q;

endmodule
`default_nettype wire

### hw/rtl/itp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_ctrl
// Token sequencer: takes one request, then pops one stack entry per cycle
// unless a result stalls, holds each operator that an operator or close
// pops until it is known whether it is the last result, and pushes or flushes as required.
// ---------------------------------------------------------------------------
module itp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tok_valid,
	input  wire itp_pkg::tok_t       tok,
	output logic                     tok_ready,
	input  wire itp_pkg::stk_entry_t top,
	output itp_pkg::ram_req_t        ram_req,
	input  wire logic                out_free,
	output itp_pkg::emit_t           emit
);
	import itp_pkg::*;

	st_t               st_q, st_d;
	tok_t              tok_q, tok_d;
	logic [STK_CW-1:0] cnt_q, cnt_d;
	logic [STK_CW-1:0] par_q, par_d;
	logic              pend_v_q, pend_v_d;
	logic [31:0]       pend_q, pend_d;

	logic              full;
	logic              pop_op;
	logic              stall;
	logic [STK_CW-1:0] cnt_m1;
	logic [STK_CW-1:0] rd_ptr;
	stk_entry_t        push_ent;

	assign full   = (cnt_q == STK_CW'(STACK_DEPTH));
	assign cnt_m1 = cnt_q - STK_CW'(1);

	// operator pops a non-paren top of higher rank, or equal rank if left assoc
	assign pop_op = (cnt_q != '0) && !top.paren &&
		((top.rank > tok_q.rank) || ((top.rank == tok_q.rank) && !tok_q.right_assoc));

	// entry pushed for an operator or an open paren
	always_comb begin
		push_ent.payload = tok_q.payload;
		if (tok_q.kind == KIND_OPEN) begin
			push_ent.paren       = 1'b1;
			push_ent.right_assoc = 1'b0;
			push_ent.rank        = '0;
		end else begin
			push_ent.paren       = 1'b0;
			push_ent.right_assoc = tok_q.right_assoc;
			push_ent.rank        = tok_q.rank;
		end
	end

	// next state, stack updates and results
	always_comb begin
		st_d          = st_q;
		tok_d         = tok_q;
		cnt_d         = cnt_q;
		par_d         = par_q;
		pend_v_d      = pend_v_q;
		pend_d        = pend_q;
		emit          = '0;
		ram_req.we    = 1'b0;
		ram_req.waddr = cnt_q[STK_AW-1:0];
		ram_req.wdata = push_ent;
		tok_ready     = 1'b0;

		case (st_q)
			ST_IDLE: begin
				tok_ready = 1'b1;
				if (tok_valid) begin
					tok_d    = tok;
					pend_v_d = 1'b0;
					st_d     = ST_RUN;
				end
			end
			ST_RUN: begin
				case (tok_q.kind)
					KIND_VALUE: begin
						emit.valid = 1'b1;
						emit.res   = '{OK_VALUE, tok_q.payload, 1'b1, ERR_NONE};
						st_d       = ST_IDLE;
					end
					KIND_OPER: begin
						// release the held operator, last when popping stops
						if (pend_v_q) begin
							emit.valid = 1'b1;
							emit.res   = '{OK_OPER, pend_q, !pop_op, ERR_NONE};
						end
						if (pop_op) begin
							pend_d   = top.payload;
							pend_v_d = 1'b1;
							cnt_d    = cnt_m1;
						end else if (full) begin
							emit.valid = 1'b1;
							emit.res   = '{OK_NONE, 32'd0, 1'b1, ERR_OVERFLOW};
							cnt_d      = '0;
							par_d      = '0;
							st_d       = ST_IDLE;
						end else begin
							ram_req.we = 1'b1;
							cnt_d      = cnt_q + STK_CW'(1);
							st_d       = ST_IDLE;
						end
					end
					KIND_OPEN: begin
						if (full) begin
							emit.valid = 1'b1;
							emit.res   = '{OK_NONE, 32'd0, 1'b1, ERR_OVERFLOW};
							cnt_d      = '0;
							par_d      = '0;
						end else begin
							ram_req.we = 1'b1;
							cnt_d      = cnt_q + STK_CW'(1);
							par_d      = par_q + STK_CW'(1);
						end
						st_d = ST_IDLE;
					end
					KIND_CLOSE: begin
						if (par_q == '0) begin
							// no matching open paren on the stack
							emit.valid = 1'b1;
							emit.res   = '{OK_NONE, 32'd0, 1'b1, ERR_PAREN};
							cnt_d      = '0;
							st_d       = ST_IDLE;
						end else begin
							if (pend_v_q) begin
								emit.valid = 1'b1;
								emit.res   = '{OK_OPER, pend_q, top.paren, ERR_NONE};
							end
							cnt_d = cnt_m1;
							if (top.paren) begin
								// drop the matching open paren
								par_d = par_q - STK_CW'(1);
								st_d  = ST_IDLE;
							end else begin
								pend_d   = top.payload;
								pend_v_d = 1'b1;
							end
						end
					end
					KIND_END: begin
						emit.valid = 1'b1;
						if (par_q != '0) begin
							emit.res = '{OK_NONE, 32'd0, 1'b1, ERR_PAREN};
							cnt_d    = '0;
							par_d    = '0;
							st_d     = ST_IDLE;
						end else if (cnt_q == '0) begin
							emit.res = '{OK_NONE, 32'd0, 1'b1, ERR_NONE};
							st_d     = ST_IDLE;
						end else begin
							// flush, last on the bottom entry
							emit.res = '{OK_OPER, top.payload, cnt_m1 == '0, ERR_NONE};
							cnt_d    = cnt_m1;
							if (cnt_m1 == '0) begin
								st_d = ST_IDLE;
							end
						end
					end
					default: begin
						st_d = ST_IDLE;
					end
				endcase
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase

		// hold everything while a result is due and the output register is occupied
		stall = emit.valid && !out_free;
		if (stall) begin
			st_d       = st_q;
			cnt_d      = cnt_q;
			par_d      = par_q;
			pend_v_d   = pend_v_q;
			pend_d     = pend_q;
			ram_req.we = 1'b0;
			emit.valid = 1'b0;
		end

		// keep the read port on the top of the next stack
		rd_ptr        = cnt_d - STK_CW'(1);
		ram_req.raddr = rd_ptr[STK_AW-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			par_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			cnt_q    <= cnt_d;
			par_q    <= par_d;
			pend_v_q <= pend_v_d;
		end
	end

	// token and held operator
	always_ff @(posedge clk) begin
		tok_q  <= tok_d;
		pend_q <= pend_d;
	end

endmodule
`default_nettype wire

### hw/rtl/infix_to_postfix_reorder_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// infix_to_postfix_reorder_unit
// Infix to postfix token reorder (shunting yard) over a 16-entry operator
// stack held in a synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
// - tok_valid/tok_ready/tok carry one infix token per request; res_valid/
//   res_ready/res carry postfix results, last marking the final result of
//   each token. Errors come as a single result with out_kind "no token".
// - A token is taken when the unit is idle, and the unit is idle again after
//   its work: popping stack entries (the matching open included), then any
//   push. One pop per cycle while no result stalls is set by the single
//   memory read port, whose registered output always holds the top of stack.
// - First result: a value's result goes to the output register; each operator
//   that a popping operator or close pops is first held in the held-operator
//   register until it is known whether it is the last result.
// - A new token can be taken while the previous last result waits in the
//   output register; a result due while the receiver stalls holds the unit.
// - Reset empties the stack and the output register; stack memory contents
//   need no clearing, as only written entries are ever used.
// ---------------------------------------------------------------------------
module infix_to_postfix_reorder_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_valid,
	output logic               tok_ready,
	input  wire itp_pkg::tok_t tok,
	output logic               res_valid,
	input  wire logic          res_ready,
	output itp_pkg::res_t      res
);
	import itp_pkg::*;

	ram_req_t   ram_req;
	stk_entry_t top;
	emit_t      emit;
	logic       out_free;

	// operator stack memory
	itp_stack_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (top)
	);

	// token sequencer
	itp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_ready (tok_ready),
		.top       (top),
		.ram_req   (ram_req),
		.out_free  (out_free),
		.emit      (emit)
	);

	// result register
	itp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.free      (out_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
`default_nettype wire

### verif/infix_to_postfix_reorder_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// infix_to_postfix_reorder_unit_tb
// Feeds infix token streams into the reorder unit and checks every postfix
// result against an operator-stack predictor kept in the bench. The streams
// are a short directed set, then random well-formed expressions, stack
// overflow runs and stray tokens. Both sides idle in random bursts, and the
// result side holds off once for a long stretch so that the unit backs up.
// ---------------------------------------------------------------------------
module infix_to_postfix_reorder_unit_tb;
	import itp_pkg::*;

	localparam int TOKEN_TARGET = 460;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;

	// ignored token kind, outside the defined set
	localparam logic [2:0]  KIND_JUNK = 3'd7;

	// operator and parenthesis symbol codes
	localparam logic [31:0] SYM_POW   = 32'h5E;
	localparam logic [31:0] SYM_OPEN  = 32'h28;
	localparam logic [31:0] SYM_CLOSE = 32'h29;
	localparam logic [31:0] SYM_ADD   = 32'h2B;
	localparam logic [31:0] SYM_MUL   = 32'h2A;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic tok_valid = 1'b0;
	logic tok_ready;
	tok_t tok       = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	tok_t       pending [$];
	res_t       postfix_due [$];
	stk_entry_t op_stk [STACK_DEPTH];
	int         op_depth = 0;

	int   n_tokens     = 0;
	int   n_checked    = 0;
	int   mismatches   = 0;
	int   gap_left     = 0;
	int   stall_left   = 0;
	int   quiet_cycles = 0;
	bit   long_done    = 1'b0;
	logic ready_next;
	res_t want;

	infix_to_postfix_reorder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// clock
	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	task automatic expect_result(input logic [1:0] k, input logic [31:0] p, input logic l,
			input logic [1:0] e);
		res_t r;
		r.out_kind    = k;
		r.out_payload = p;
		r.last        = l;
		r.error       = e;
		postfix_due.insert(postfix_due.size(), r);
	endtask

	// pop cnt operators off the top, last flag on the final one
	task automatic expect_pops(input int cnt);
		int i;
		for (i = 0; i < cnt; i++)
			expect_result(OK_OPER, op_stk[op_depth - 1 - i].payload, i == cnt - 1, ERR_NONE);
		op_depth -= cnt;
	endtask

	// error: stack dropped, single no-token result
	task automatic expect_abort(input logic [1:0] e);
		op_depth = 0;
		expect_result(OK_NONE, '0, 1'b1, e);
	endtask

	task automatic postfix_of_token(input tok_t t);
		stk_entry_t ent;
		int         pops;
		int         i;
		bit         paren_seen;
		bit         do_push;
		pops       = 0;
		paren_seen = 1'b0;
		do_push    = 1'b0;
		ent        = '0;
		for (i = 0; i < op_depth; i++)
			if (op_stk[i].paren)
				paren_seen = 1'b1;
		case (t.kind)
			KIND_VALUE: begin
				expect_result(OK_VALUE, t.payload, 1'b1, ERR_NONE);
			end
			KIND_OPER: begin
				// pop while the top binds at least as tightly; equal rank stops a right-assoc one
				while (pops < op_depth && !op_stk[op_depth - 1 - pops].paren &&
						(op_stk[op_depth - 1 - pops].rank > t.rank ||
						(op_stk[op_depth - 1 - pops].rank == t.rank && !t.right_assoc)))
					pops++;
				expect_pops(pops);
				ent.right_assoc = t.right_assoc;
				ent.rank        = t.rank;
				ent.payload     = t.payload;
				do_push         = 1'b1;
			end
			KIND_OPEN: begin
				ent.paren   = 1'b1;
				ent.payload = t.payload;
				do_push     = 1'b1;
			end
			KIND_CLOSE: begin
				if (!paren_seen) begin
					expect_abort(ERR_PAREN);
				end else begin
					while (!op_stk[op_depth - 1 - pops].paren)
						pops++;
					expect_pops(pops);
					op_depth--;
				end
			end
			KIND_END: begin
				if (paren_seen)
					expect_abort(ERR_PAREN);
				else if (op_depth == 0)
					expect_result(OK_NONE, '0, 1'b1, ERR_NONE);
				else
					expect_pops(op_depth);
			end
			default: begin
			end
		endcase
		// push onto a full stack aborts the expression
		if (do_push) begin
			if (op_depth >= STACK_DEPTH) begin
				expect_abort(ERR_OVERFLOW);
			end else begin
				op_stk[op_depth] = ent;
				op_depth++;
			end
		end
	endtask

	// ---------------- stimulus ----------------

	function automatic tok_t mk_tok(input logic [2:0] k, input logic [31:0] p,
			input logic [3:0] r, input logic ra);
		tok_t t;
		t.kind        = k;
		t.payload     = p;
		t.rank        = r;
		t.right_assoc = ra;
		return t;
	endfunction

	task automatic queue_tok(input tok_t t);
		pending.insert(pending.size(), t);
		n_tokens++;
	endtask

	// mostly low ranks so that equal ranks meet often
	task automatic queue_op();
		logic [3:0] r;
		r = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
		queue_tok(mk_tok(KIND_OPER, $urandom, r, 1'($urandom_range(0, 1))));
	endtask

	task automatic queue_term(input int lvl);
		if (lvl < 3 && $urandom_range(0, 3) == 0) begin
			queue_tok(mk_tok(KIND_OPEN, SYM_OPEN, 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
			queue_expr(lvl + 1);
			queue_tok(mk_tok(KIND_CLOSE, SYM_CLOSE, 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
		end else begin
			queue_tok(mk_tok(KIND_VALUE, $urandom, 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
		end
	endtask

	task automatic queue_expr(input int lvl);
		int terms;
		int i;
		terms = $urandom_range(1, 4);
		for (i = 0; i < terms; i++) begin
			if (i > 0)
				queue_op();
			queue_term(lvl);
		end
	endtask

	// stack filler: opens and rank-15 right-assoc operators never pop each other
	task automatic queue_deep(input int pushes);
		int i;
		int closes;
		for (i = 0; i < pushes; i++) begin
			if ($urandom_range(0, 1))
				queue_tok(mk_tok(KIND_OPEN, SYM_OPEN, 4'($urandom_range(0, 15)), 1'b0));
			else
				queue_tok(mk_tok(KIND_OPER, $urandom, 4'd15, 1'b1));
			if ($urandom_range(0, 3) == 0)
				queue_tok(mk_tok(KIND_VALUE, $urandom, 4'($urandom_range(0, 15)), 1'b0));
		end
		closes = $urandom_range(0, pushes);
		for (i = 0; i < closes; i++)
			queue_tok(mk_tok(KIND_CLOSE, SYM_CLOSE, 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
		queue_tok(mk_tok(KIND_END, '0, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
	endtask

	task automatic queue_noise();
		int n;
		int i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			queue_tok(mk_tok(3'($urandom_range(0, 7)), $urandom, 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
	endtask

	// ---------------- sequence ----------------

	initial begin
		int  sel;
		bit  first_deep;
		first_deep = 1'b1;

		// directed: field extremes, every kind, the stack corner cases
		queue_tok(mk_tok(KIND_VALUE, 32'h0, 4'd0, 1'b0));
		queue_tok(mk_tok(KIND_VALUE, 32'hFFFF_FFFF, 4'd15, 1'b1));
		queue_tok(mk_tok(KIND_END, '0, 4'd0, 1'b0));                  // empty stack
		queue_tok(mk_tok(KIND_CLOSE, SYM_CLOSE, 4'd0, 1'b0));         // no open stacked
		queue_tok(mk_tok(KIND_JUNK, 32'hFFFF_FFFF, 4'd15, 1'b1));     // ignored
		queue_tok(mk_tok(KIND_OPER, 32'hFFFF_FFFF, 4'd15, 1'b0));     // nothing to pop
		queue_tok(mk_tok(KIND_OPER, SYM_POW, 4'd15, 1'b1));           // equal rank, right assoc
		queue_tok(mk_tok(KIND_OPER, SYM_ADD, 4'd1, 1'b0));            // pops both
		queue_tok(mk_tok(KIND_OPEN, SYM_OPEN, 4'd0, 1'b0));
		queue_tok(mk_tok(KIND_CLOSE, SYM_CLOSE, 4'd0, 1'b0));         // straight onto its open
		queue_tok(mk_tok(KIND_OPEN, SYM_OPEN, 4'd0, 1'b0));
		queue_tok(mk_tok(KIND_OPER, SYM_MUL, 4'd15, 1'b0));           // open is never popped
		queue_tok(mk_tok(KIND_CLOSE, SYM_CLOSE, 4'd0, 1'b0));
		queue_tok(mk_tok(KIND_END, '0, 4'd0, 1'b0));                  // flush
		queue_tok(mk_tok(KIND_OPEN, SYM_OPEN, 4'd0, 1'b0));
		queue_tok(mk_tok(KIND_END, '0, 4'd0, 1'b0));                  // open left over

		// random: mostly whole expressions, some stack fillers and stray tokens
		while (n_tokens < TOKEN_TARGET) begin
			sel = $urandom_range(0, 99);
			if (first_deep) begin
				queue_deep(STACK_DEPTH + 1);
				first_deep = 1'b0;
			end else if (sel < 10) begin
				queue_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2));
			end else if (sel < 80) begin
				queue_expr(0);
				queue_tok(mk_tok(KIND_END, '0, 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1))));
			end else begin
				queue_noise();
			end
		end
		queue_tok(mk_tok(KIND_END, '0, 4'd0, 1'b0));

		// reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		while (pending.size() != 0 || tok_valid)
			@(posedge clk);
		while (postfix_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ---------------- token driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
			tok       <= '0;
		end else begin
			// request taken at this edge
			if (tok_valid && tok_ready)
				postfix_of_token(tok);
			// next request, with idle bursts outside the calm stretches
			if (!tok_valid || tok_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					tok_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					if (pending.size() >= 50 && (pending.size() % 160) >= 40 &&
							$urandom_range(0, 99) < 8) begin
						gap_left = $urandom_range(1, 18) - 1;
						tok_valid <= 1'b0;
					end else begin
						tok       <= pending.pop_front();
						tok_valid <= 1'b1;
					end
				end else begin
					tok_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				n_checked++;
				if (postfix_due.size() == 0) begin
					$error("unexpected result: out_kind %0d out_payload %h last %0d error %0d",
						res.out_kind, res.out_payload, res.last, res.error);
					mismatches++;
				end else begin
					want = postfix_due.pop_front();
					if (res.out_kind !== want.out_kind) begin
						$error("out_kind: expected %0d, got %0d", want.out_kind, res.out_kind);
						mismatches++;
					end
					if (res.out_payload !== want.out_payload) begin
						$error("out_payload: expected %h, got %h", want.out_payload,
							res.out_payload);
						mismatches++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, res.last);
						mismatches++;
					end
					if (res.error !== want.error) begin
						$error("error: expected %0d, got %0d", want.error, res.error);
						mismatches++;
					end
				end
			end
			// stall bursts, plus one long hold-off that backs the unit up
			if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else if (!long_done && n_checked >= 150) begin
				long_done  = 1'b1;
				stall_left = LONG_HOLD - 1;
				ready_next = 1'b0;
			end else if (pending.size() >= 50 && (n_checked % 140) >= 30 &&
					$urandom_range(0, 99) < 8) begin
				stall_left = $urandom_range(1, 18) - 1;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			res_ready <= ready_next;
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (!arst_n || (tok_valid && tok_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

### filelist.f
hw/rtl/itp_pkg.sv
hw/rtl/itp_stack_ram.sv
hw/rtl/itp_out_reg.sv
hw/rtl/itp_ctrl.sv
hw/rtl/infix_to_postfix_reorder_unit.sv
verif/infix_to_postfix_reorder_unit_tb.sv
